[rtl/pcpa_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and sizes for the per-cpu page allocator
// no dependencies

package pcpa_pkg;

    localparam int NUM_PAGES = 32768;
    localparam int NUM_CPUS  = 8;

    localparam int FRAME_W   = 24;
    localparam int CPU_ID_W  = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int CPU_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    // request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_FRAME   = 1'd1;

    localparam logic [FRAME_W-1:0] FIRST_FRAME_RST = 24'd524288;
    localparam logic [FRAME_W-1:0] TOP_FRAME_RST   = 24'd557056;

    // list head or next link: valid bit and page index
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] idx;
    } link_t;

    localparam int LINK_W = PAGE_W + 1;

    // head lookup result
    typedef struct packed {
        logic             found;
        logic [CPU_W-1:0] cpu;
        link_t            head;
    } head_sel_t;

    // head write
    typedef struct packed {
        logic             we;
        logic [CPU_W-1:0] cpu;
        link_t            head;
    } head_upd_t;

endpackage

[rtl/pcpa_if.sv]
`timescale 1ns / 1ps
// channel interfaces: request, response and configuration write
// depends on pcpa_pkg

interface pcpa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [pcpa_pkg::CPU_ID_W-1:0] cpu_id;
    logic [pcpa_pkg::FRAME_W-1:0]  page_frame;

    modport source (output valid, output req_type, output cpu_id, output page_frame,
                    input ready);
    modport sink   (input valid, input req_type, input cpu_id, input page_frame,
                    output ready);
endinterface

interface pcpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pcpa_pkg::FRAME_W-1:0]  granted_frame;
    logic [pcpa_pkg::STATUS_W-1:0] status;

    modport source (output valid, output granted_frame, output status, input ready);
    modport sink   (input valid, input granted_frame, input status, output ready);
endinterface

interface pcpa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pcpa_pkg::CFG_IDX_W-1:0] index;
    logic [pcpa_pkg::FRAME_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/pcpa_link_ram.sv]
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port and one registered read port
// no dependencies

module pcpa_link_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/pcpa_heads.sv]
`timescale 1ns / 1ps
// per-cpu list head registers with own-or-steal selection
// depends on pcpa_pkg

module pcpa_heads (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pcpa_pkg::CPU_W-1:0]  cpu,
    input  logic                        is_free,
    input  pcpa_pkg::head_upd_t         upd,
    output pcpa_pkg::head_sel_t         sel
);
    import pcpa_pkg::*;

    link_t            heads_reg [NUM_CPUS];
    logic [CPU_W-1:0] lowest;
    logic             any_valid;
    logic [CPU_W-1:0] sel_cpu;

    // lowest-numbered cpu with a nonempty list
    always_comb
    begin
        lowest    = '0;
        any_valid = 1'b0;
        for (int i = NUM_CPUS - 1; i >= 0; i--)
        begin
            if (heads_reg[i].valid)
            begin
                lowest    = CPU_W'(i);
                any_valid = 1'b1;
            end
        end
    end

    // a free always uses its own list, an alloc steals only when its own is empty
    assign sel_cpu   = (is_free || heads_reg[cpu].valid) ? cpu : lowest;
    assign sel.cpu   = sel_cpu;
    assign sel.head  = heads_reg[sel_cpu];
    assign sel.found = any_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                heads_reg[i].valid <= 1'b0;
                heads_reg[i].idx   <= '0;
            end
        end
        else if (upd.we)
        begin
            heads_reg[upd.cpu] <= upd.head;
        end
    end

endmodule

[rtl/per_cpu_page_allocator.sv]
`timescale 1ns / 1ps
// response: a free or an out-of-memory alloc answers in the cycle after acceptance,
// an alloc that pops a list answers after passing through the pop state (next-link memory read)
// throughput: one free per cycle while responses are taken; no request is accepted in the pop state
// reset: all lists empty, first_frame and top_frame at their reset values;
// the next-link memory is not cleared and needs no clearing pass
// depends on pcpa_pkg, pcpa_if, pcpa_heads, pcpa_link_ram

module per_cpu_page_allocator (
    input  logic      clk,
    input  logic      rst_n,
    pcpa_cfg_if.sink  cfg,
    pcpa_req_if.sink  req,
    pcpa_rsp_if.source rsp
);
    import pcpa_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    state_t              state_reg;
    logic                out_valid_reg;
    logic [FRAME_W-1:0]  out_frame_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CPU_W-1:0]    pop_cpu_reg;
    logic [PAGE_W-1:0]   pop_idx_reg;
    logic [FRAME_W-1:0]  first_frame_reg;
    logic [FRAME_W-1:0]  top_frame_reg;

    logic                accept;
    logic                is_free;
    logic [CPU_W-1:0]    cpu;
    logic [FRAME_W:0]    diff;
    logic                bad_free;
    logic [PAGE_W-1:0]   free_idx;
    head_sel_t           sel;
    head_upd_t           upd;
    logic [LINK_W-1:0]   rd_data;
    link_t               next_link;
    logic                out_valid_next;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign is_free   = (req.req_type == REQ_FREE);
    assign cpu       = req.cpu_id[CPU_W-1:0];
    assign cfg.ready = 1'b1;

    // page index and range checks for a free
    assign diff     = {1'b0, req.page_frame} - {1'b0, first_frame_reg};
    assign free_idx = diff[PAGE_W-1:0];
    assign bad_free = diff[FRAME_W] || (req.page_frame >= top_frame_reg) ||
                      (diff[FRAME_W-1:0] >= FRAME_W'(NUM_PAGES));

    pcpa_heads u_heads (
        .clk     (clk),
        .rst_n   (rst_n),
        .cpu     (cpu),
        .is_free (is_free),
        .upd     (upd),
        .sel     (sel)
    );

    pcpa_link_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_PAGES)
    ) u_links (
        .clk     (clk),
        .wr_en   (accept && is_free && !bad_free),
        .wr_addr (free_idx),
        .wr_data (sel.head),
        .rd_en   (accept && !is_free && sel.found),
        .rd_addr (sel.head.idx),
        .rd_data (rd_data)
    );

    assign next_link = link_t'(rd_data);

    always_comb
    begin
        upd.we   = 1'b0;
        upd.cpu  = cpu;
        upd.head = '{valid: 1'b1, idx: free_idx};
        if (state_reg == S_POP)
        begin
            upd.we   = 1'b1;
            upd.cpu  = pop_cpu_reg;
            upd.head = next_link;
        end
        else if (accept && is_free && !bad_free)
        begin
            upd.we = 1'b1;
        end
    end

    // output word stays while stalled, a new one loads on a finished request
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        if (state_reg == S_POP)
        begin
            out_valid_next = 1'b1;
        end
        else if (accept && (is_free || !sel.found))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_frame_reg <= FIRST_FRAME_RST;
            top_frame_reg   <= TOP_FRAME_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FIRST_FRAME: first_frame_reg <= cfg.data;
                CFG_TOP_FRAME:   top_frame_reg   <= cfg.data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_frame_reg  <= '0;
            out_status_reg <= ST_OK;
            pop_cpu_reg    <= '0;
            pop_idx_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_free)
                        begin
                            out_frame_reg  <= '0;
                            out_status_reg <= bad_free ? ST_BAD_FREE : ST_OK;
                        end
                        else if (!sel.found)
                        begin
                            out_frame_reg  <= '0;
                            out_status_reg <= ST_OOM;
                        end
                        else
                        begin
                            pop_cpu_reg <= sel.cpu;
                            pop_idx_reg <= sel.head.idx;
                            state_reg   <= S_POP;
                        end
                    end
                end
                S_POP:
                begin
                    // output slot is empty here: the alloc was taken only with it free or being drained
                    out_frame_reg  <= first_frame_reg + FRAME_W'(pop_idx_reg);
                    out_status_reg <= ST_OK;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted_frame = out_frame_reg;
    assign rsp.status        = out_status_reg;

endmodule

[rtl/pcpa_checker.sv]
`timescale 1ns / 1ps
// port-level checks on the per-cpu page allocator, bound to the top level
// depends on pcpa_pkg

module pcpa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          req_type,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [pcpa_pkg::FRAME_W-1:0]  granted_frame,
    input logic [pcpa_pkg::STATUS_W-1:0] status
);
    import pcpa_pkg::*;

    // a stalled word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted_frame) && $stable(status))
        else $error("response word changed while stalled");

    // no frame is handed out with a failing status
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> granted_frame == '0)
        else $error("nonzero frame with failing status");

    // a free answers on the next cycle
    a_free_lat: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_FREE |=> rsp_valid)
        else $error("free response missing");

    // no new request is taken while a result is stuck
    a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request taken while response stalled");

endmodule

bind per_cpu_page_allocator pcpa_checker u_pcpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_type      (req.req_type),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .granted_frame (rsp.granted_frame),
    .status        (rsp.status)
);
